// ----- hdl/qslerp_pkg.sv -----
// Shared types, constants and the arctangent table for the quaternion slerp core.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package qslerp_pkg;

  // Number of CORDIC iterations in the arctangent and sine units (8 to 24)
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_LEN   = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

  // Stage counts of the square root and reciprocal units
  localparam int SQRT_STAGES = 31;
  localparam int DIV_STAGES  = 26;

  // Stream widths
  localparam int IN_W   = 152;
  localparam int OUT_W  = 64;
  localparam int USER_W = 2;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic signed [19:0] CORDIC_GAIN_INV = 20'sd39797;
  localparam logic [33:0] NEAR_LIMIT = 34'd1073740800; // 2^30 - 2^10
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  typedef enum logic [1:0] {
    PATH_FROM   = 2'd0,
    PATH_TO     = 2'd1,
    PATH_LINEAR = 2'd2,
    PATH_SPHERE = 2'd3
  } path_e;

  // Per-item context that travels down the pipeline
  typedef struct packed {
    path_e              path;
    logic [3:0][16:0]   fq;   // start quaternion, or the copied one
    logic [3:0][16:0]   gq;   // end quaternion, hemisphere corrected
    logic [16:0]        tw;   // blend factor, Q.16
    logic [29:0]        c;    // |dot|, Q.30
    logic [30:0]        s2;   // 1 - cos^2, Q.30
    logic [30:0]        r;    // sin omega, Q.30
    logic [25:0]        inv;  // 1 / sin omega, Q.16
    logic signed [19:0] om;   // omega, Q.16 radians
    logic signed [19:0] a0;
    logic signed [19:0] a1;
    logic signed [19:0] sn0;
    logic signed [19:0] sn1;
  } ctx_t;

  // Finished result
  typedef struct packed {
    logic [3:0][15:0] q;
    path_e            path;
  } res_t;

  // Arctangent of 2^-i in Q.16 radians, rounded to nearest
  function automatic logic [15:0] atan_q16(input int idx);
    logic [15:0] val;
    case (idx)
      0:       val = 16'd51472;
      1:       val = 16'd30386;
      2:       val = 16'd16055;
      3:       val = 16'd8150;
      4:       val = 16'd4091;
      5:       val = 16'd2047;
      6:       val = 16'd1024;
      7:       val = 16'd512;
      8:       val = 16'd256;
      9:       val = 16'd128;
      10:      val = 16'd64;
      11:      val = 16'd32;
      12:      val = 16'd16;
      13:      val = 16'd8;
      14:      val = 16'd4;
      15:      val = 16'd2;
      16:      val = 16'd1;
      default: val = 16'd0;
    endcase
    return val;
  endfunction

endpackage

// ----- hdl/qslerp_front.sv -----
// Front end: dot product, hemisphere flip, path selection and 1 - cos^2.
// Three register stages. Depends on qslerp_pkg.
`timescale 1ns / 1ps

module qslerp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [qslerp_pkg::IN_W-1:0] data_i,
  output logic                        valid_o,
  output qslerp_pkg::ctx_t            ctx_o
);
  import qslerp_pkg::*;

  logic [3:0][15:0]   f_q, g_q;
  logic [17:0]        t_q;
  logic               same_q;
  logic [3:0][31:0]   p_d, p_q;
  logic               v1_q, v2_q, v3_q;

  logic signed [33:0] csum;
  logic [33:0]        cabs;
  logic               neg;
  ctx_t               ctx2_d, ctx2_q, ctx3_d, ctx3_q;
  logic [59:0]        cc;

  // Form the four partial products of the dot product
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      p_d[k] = 32'($signed(data_i[16*k +: 16]) * $signed(data_i[64+16*k +: 16]));
    end
  end

  // Stage 1: capture operands and products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        f_q[k] <= data_i[16*k +: 16];
        g_q[k] <= data_i[64+16*k +: 16];
      end
      t_q    <= data_i[145:128];
      same_q <= (data_i[63:0] == data_i[127:64]);
      p_q    <= p_d;
    end
  end

  // Stage 2: sum, flip onto the near hemisphere, choose the path
  always_comb begin
    csum = '0;
    for (int k = 0; k < 4; k++) begin
      csum = csum + $signed({{2{p_q[k][31]}}, p_q[k]});
    end
    neg  = csum[33];
    cabs = neg ? 34'(-csum) : 34'(csum);

    ctx2_d = '0;
    if ($signed(t_q) <= 18'sd0) begin
      ctx2_d.path = PATH_FROM;
    end else if (($signed(t_q) >= 18'sd65536) || same_q) begin
      ctx2_d.path = PATH_TO;
    end else if (cabs < NEAR_LIMIT) begin
      ctx2_d.path = PATH_SPHERE;
    end else begin
      ctx2_d.path = PATH_LINEAR;
    end

    for (int k = 0; k < 4; k++) begin
      ctx2_d.fq[k] = (ctx2_d.path == PATH_TO) ? {g_q[k][15], g_q[k]} : {f_q[k][15], f_q[k]};
      ctx2_d.gq[k] = neg ? 17'(-$signed({g_q[k][15], g_q[k]})) : {g_q[k][15], g_q[k]};
    end
    ctx2_d.tw = t_q[16:0];
    ctx2_d.c  = cabs[29:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx2_q <= ctx2_d;
    end
  end

  // Stage 3: square the cosine and subtract from one
  always_comb begin
    cc        = ctx2_q.c * ctx2_q.c;
    ctx3_d    = ctx2_q;
    ctx3_d.s2 = ONE_Q30 - {1'b0, cc[59:30]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx3_q <= ctx3_d;
    end
  end

  assign valid_o = v3_q;
  assign ctx_o   = ctx3_q;

endmodule

// ----- hdl/qslerp_sqrt.sv -----
// Pipelined integer square root, one result bit per stage: r = floor(sqrt(s2 * 2^30)).
// Depends on qslerp_pkg.
`timescale 1ns / 1ps

module qslerp_sqrt (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  qslerp_pkg::ctx_t ctx_i,
  output logic             valid_o,
  output qslerp_pkg::ctx_t ctx_o
);
  import qslerp_pkg::*;

  logic [60:0] n_w   [SQRT_STAGES+1];
  logic [61:0] res_w [SQRT_STAGES+1];
  ctx_t        ctx_w [SQRT_STAGES+1];
  logic        v_w   [SQRT_STAGES+1];

  assign n_w[0]   = {ctx_i.s2, 30'd0};
  assign res_w[0] = '0;
  assign ctx_w[0] = ctx_i;
  assign v_w[0]   = valid_i;

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    localparam int K = SQRT_STAGES - 1 - j;
    logic [61:0] bit_c, sum_c, res_d, res_q;
    logic [60:0] n_d, n_q;
    ctx_t        ctx_q;
    logic        v_q;

    // Try to subtract the current trial bit
    always_comb begin
      bit_c = 62'd1 << (2 * K);
      sum_c = res_w[j] + bit_c;
      if ({1'b0, n_w[j]} >= sum_c) begin
        n_d   = n_w[j] - sum_c[60:0];
        res_d = (res_w[j] >> 1) + bit_c;
      end else begin
        n_d   = n_w[j];
        res_d = res_w[j] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q   <= n_d;
        res_q <= res_d;
        ctx_q <= ctx_w[j];
      end
    end

    assign n_w[j+1]   = n_q;
    assign res_w[j+1] = res_q;
    assign ctx_w[j+1] = ctx_q;
    assign v_w[j+1]   = v_q;
  end

  // Attach the root to the context
  always_comb begin
    ctx_o   = ctx_w[SQRT_STAGES];
    ctx_o.r = res_w[SQRT_STAGES][30:0];
  end

  assign valid_o = v_w[SQRT_STAGES];

endmodule

// ----- hdl/qslerp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage: inv = floor(2^46 / r).
// Depends on qslerp_pkg.
`timescale 1ns / 1ps

module qslerp_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  qslerp_pkg::ctx_t ctx_i,
  output logic             valid_o,
  output qslerp_pkg::ctx_t ctx_o
);
  import qslerp_pkg::*;

  logic [46:0] rem_w [DIV_STAGES+1];
  logic [25:0] quo_w [DIV_STAGES+1];
  ctx_t        ctx_w [DIV_STAGES+1];
  logic        v_w   [DIV_STAGES+1];

  assign rem_w[0] = 47'd1 << 46;
  assign quo_w[0] = '0;
  assign ctx_w[0] = ctx_i;
  assign v_w[0]   = valid_i;

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    localparam int I = DIV_STAGES - 1 - j;
    logic [56:0] dv;
    logic [46:0] rem_d, rem_q;
    logic [25:0] quo_d, quo_q;
    ctx_t        ctx_q;
    logic        v_q;

    // Compare against the shifted divisor and subtract when it fits
    always_comb begin
      dv = 57'(ctx_w[j].r) << I;
      if ({10'd0, rem_w[j]} >= dv) begin
        rem_d = rem_w[j] - dv[46:0];
        quo_d = quo_w[j] | (26'd1 << I);
      end else begin
        rem_d = rem_w[j];
        quo_d = quo_w[j];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_w[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        ctx_q <= ctx_w[j];
      end
    end

    assign rem_w[j+1] = rem_q;
    assign quo_w[j+1] = quo_q;
    assign ctx_w[j+1] = ctx_q;
    assign v_w[j+1]   = v_q;
  end

  always_comb begin
    ctx_o     = ctx_w[DIV_STAGES];
    ctx_o.inv = quo_w[DIV_STAGES];
  end

  assign valid_o = v_w[DIV_STAGES];

endmodule

// ----- hdl/qslerp_angle.sv -----
// Angle unit: CORDIC arctangent for omega, angle scaling by t and 1 - t, and two
// CORDIC sine lanes. One iteration per stage. Depends on qslerp_pkg.
`timescale 1ns / 1ps

module qslerp_angle (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  qslerp_pkg::ctx_t ctx_i,
  output logic             valid_o,
  output qslerp_pkg::ctx_t ctx_o
);
  import qslerp_pkg::*;

  // Vectoring section
  logic signed [19:0] ax_w [CORDIC_LEN+1];
  logic signed [19:0] ay_w [CORDIC_LEN+1];
  logic signed [19:0] az_w [CORDIC_LEN+1];
  ctx_t               actx_w [CORDIC_LEN+1];
  logic               av_w   [CORDIC_LEN+1];

  assign ax_w[0]   = $signed({4'd0, ctx_i.c[29:14]});
  assign ay_w[0]   = $signed({3'd0, ctx_i.r[30:14]});
  assign az_w[0]   = '0;
  assign actx_w[0] = ctx_i;
  assign av_w[0]   = valid_i;

  for (genvar i = 0; i < CORDIC_LEN; i++) begin : g_atan
    logic signed [19:0] x_d, y_d, z_d, x_q, y_q, z_q, at;
    ctx_t               ctx_q;
    logic               v_q;

    // Rotate the vector toward the x axis
    always_comb begin
      at = $signed({4'd0, atan_q16(i)});
      if (!ay_w[i][19]) begin
        x_d = ax_w[i] + (ay_w[i] >>> i);
        y_d = ay_w[i] - (ax_w[i] >>> i);
        z_d = az_w[i] + at;
      end else begin
        x_d = ax_w[i] - (ay_w[i] >>> i);
        y_d = ay_w[i] + (ax_w[i] >>> i);
        z_d = az_w[i] - at;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= av_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q   <= x_d;
        y_q   <= y_d;
        z_q   <= z_d;
        ctx_q <= actx_w[i];
      end
    end

    assign ax_w[i+1]   = x_q;
    assign ay_w[i+1]   = y_q;
    assign az_w[i+1]   = z_q;
    assign actx_w[i+1] = ctx_q;
    assign av_w[i+1]   = v_q;
  end

  // Scale omega by both weights
  logic [16:0]        wt0;
  logic signed [37:0] pa0, pa1;
  ctx_t               sc_d, sc_q;
  logic               sc_v_q;

  always_comb begin
    wt0     = ONE_Q16 - actx_w[CORDIC_LEN].tw;
    pa0     = $signed({1'b0, wt0}) * az_w[CORDIC_LEN];
    pa1     = $signed({1'b0, actx_w[CORDIC_LEN].tw}) * az_w[CORDIC_LEN];
    sc_d    = actx_w[CORDIC_LEN];
    sc_d.om = az_w[CORDIC_LEN];
    sc_d.a0 = pa0[35:16];
    sc_d.a1 = pa1[35:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_v_q <= 1'b0;
    end else if (en_i) begin
      sc_v_q <= av_w[CORDIC_LEN];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_q <= sc_d;
    end
  end

  // Rotation section, two lanes side by side
  logic signed [19:0] sx_w [CORDIC_LEN+1][2];
  logic signed [19:0] sy_w [CORDIC_LEN+1][2];
  logic signed [19:0] sz_w [CORDIC_LEN+1][2];
  ctx_t               sctx_w [CORDIC_LEN+1];
  logic               sv_w   [CORDIC_LEN+1];

  assign sx_w[0][0] = CORDIC_GAIN_INV;
  assign sx_w[0][1] = CORDIC_GAIN_INV;
  assign sy_w[0][0] = '0;
  assign sy_w[0][1] = '0;
  assign sz_w[0][0] = sc_q.a0;
  assign sz_w[0][1] = sc_q.a1;
  assign sctx_w[0]  = sc_q;
  assign sv_w[0]    = sc_v_q;

  for (genvar i = 0; i < CORDIC_LEN; i++) begin : g_sin
    logic signed [19:0] x_d [2];
    logic signed [19:0] y_d [2];
    logic signed [19:0] z_d [2];
    logic signed [19:0] x_q [2];
    logic signed [19:0] y_q [2];
    logic signed [19:0] z_q [2];
    logic signed [19:0] at;
    ctx_t               ctx_q;
    logic               v_q;

    // Rotate each lane toward its residual angle
    always_comb begin
      at = $signed({4'd0, atan_q16(i)});
      for (int l = 0; l < 2; l++) begin
        if (!sz_w[i][l][19]) begin
          x_d[l] = sx_w[i][l] - (sy_w[i][l] >>> i);
          y_d[l] = sy_w[i][l] + (sx_w[i][l] >>> i);
          z_d[l] = sz_w[i][l] - at;
        end else begin
          x_d[l] = sx_w[i][l] + (sy_w[i][l] >>> i);
          y_d[l] = sy_w[i][l] - (sx_w[i][l] >>> i);
          z_d[l] = sz_w[i][l] + at;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= sv_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q   <= x_d;
        y_q   <= y_d;
        z_q   <= z_d;
        ctx_q <= sctx_w[i];
      end
    end

    assign sx_w[i+1]   = x_q;
    assign sy_w[i+1]   = y_q;
    assign sz_w[i+1]   = z_q;
    assign sctx_w[i+1] = ctx_q;
    assign sv_w[i+1]   = v_q;
  end

  always_comb begin
    ctx_o     = sctx_w[CORDIC_LEN];
    ctx_o.sn0 = sy_w[CORDIC_LEN][0];
    ctx_o.sn1 = sy_w[CORDIC_LEN][1];
  end

  assign valid_o = sv_w[CORDIC_LEN];

endmodule

// ----- hdl/qslerp_blend.sv -----
// Blend back end: weight selection, weighted sum of the quaternions, rounding
// and saturation to Q1.15. Three register stages. Depends on qslerp_pkg.
`timescale 1ns / 1ps

module qslerp_blend (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  qslerp_pkg::ctx_t ctx_i,
  output logic             valid_o,
  output qslerp_pkg::res_t res_o
);
  import qslerp_pkg::*;

  logic signed [46:0] pw0, pw1;
  logic signed [29:0] w0_d, w1_d, w0_q, w1_q;
  logic [3:0][16:0]   f1_q, g1_q;
  path_e              path1_q, path2_q;
  logic               v1_q, v2_q, v3_q;
  logic [3:0][46:0]   m0_d, m1_d, m0_q, m1_q;
  logic signed [47:0] acc;
  logic signed [31:0] shr;
  res_t               res_d, res_q;

  // Stage 1: pick the weights for the path
  always_comb begin
    pw0 = ctx_i.sn0 * $signed({1'b0, ctx_i.inv});
    pw1 = ctx_i.sn1 * $signed({1'b0, ctx_i.inv});
    case (ctx_i.path)
      PATH_SPHERE: begin
        w0_d = pw0[45:16];
        w1_d = pw1[45:16];
      end
      PATH_LINEAR: begin
        w0_d = $signed({13'd0, ONE_Q16 - ctx_i.tw});
        w1_d = $signed({13'd0, ctx_i.tw});
      end
      default: begin
        w0_d = $signed({13'd0, ONE_Q16});
        w1_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w0_q    <= w0_d;
      w1_q    <= w1_d;
      f1_q    <= ctx_i.fq;
      g1_q    <= ctx_i.gq;
      path1_q <= ctx_i.path;
    end
  end

  // Stage 2: weight each component
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      m0_d[k] = 47'(w0_q * $signed(f1_q[k]));
      m1_d[k] = 47'(w1_q * $signed(g1_q[k]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m0_q    <= m0_d;
      m1_q    <= m1_d;
      path2_q <= path1_q;
    end
  end

  // Stage 3: add, round, saturate
  always_comb begin
    res_d.path = path2_q;
    acc = '0;
    shr = '0;
    for (int k = 0; k < 4; k++) begin
      acc = $signed({m0_q[k][46], m0_q[k]}) + $signed({m1_q[k][46], m1_q[k]}) + 48'sd32768;
      shr = acc[47:16];
      if (shr > 32'sd32767) begin
        res_d.q[k] = 16'h7fff;
      end else if (shr < -32'sd32768) begin
        res_d.q[k] = 16'h8000;
      end else begin
        res_d.q[k] = shr[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = v3_q;
  assign res_o   = res_q;

endmodule

// ----- hdl/quaternion_slerp_core.sv -----
// Top level of the quaternion slerp core: stream ports, pipeline chain and output register.
// Depends on qslerp_pkg and the front, sqrt, div, angle and blend modules.
`timescale 1ns / 1ps

// Spherical interpolation of two Q1.15 quaternions by a Q2.16 blend factor, one
// transaction per clock unless a stalled output holds the chain. The pipeline is 3 front
// stages, 31 square root stages, 26 divider stages, 2*CORDIC_STEPS+1 CORDIC stages,
// 3 blend stages and one output register. Every stage advances together; a stalled
// output holds the whole chain except that a finished result can still move into an
// empty output register, so input keeps flowing while the last pipeline stage is
// empty. path_taken on tuser tells which rule produced the result.

module quaternion_slerp_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // from_w, from_x, from_y, from_z, to_w, to_x, to_y, to_z (16 each), blend (18), pad
  input  logic [qslerp_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_w, out_x, out_y, out_z (16 each)
  output logic [qslerp_pkg::OUT_W-1:0]  m_axis_tdata,
  // path_taken (2)
  output logic [qslerp_pkg::USER_W-1:0] m_axis_tuser
);
  import qslerp_pkg::*;

  logic en;
  logic fr_v, sq_v, dv_v, an_v, bl_v;
  ctx_t fr_ctx, sq_ctx, dv_ctx, an_ctx;
  res_t bl_res, out_q;
  logic out_v_q;

  // Advance when the last stage is empty or the output register can take it
  assign en            = !bl_v || !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  qslerp_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid), .data_i(s_axis_tdata),
    .valid_o(fr_v), .ctx_o(fr_ctx)
  );

  qslerp_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fr_v), .ctx_i(fr_ctx),
    .valid_o(sq_v), .ctx_o(sq_ctx)
  );

  qslerp_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_v), .ctx_i(sq_ctx),
    .valid_o(dv_v), .ctx_o(dv_ctx)
  );

  qslerp_angle u_angle (
    .clk_i, .rst_ni, .en_i(en), .valid_i(dv_v), .ctx_i(dv_ctx),
    .valid_o(an_v), .ctx_o(an_ctx)
  );

  qslerp_blend u_blend (
    .clk_i, .rst_ni, .en_i(en), .valid_i(an_v), .ctx_i(an_ctx),
    .valid_o(bl_v), .res_o(bl_res)
  );

  // Output register: load when empty or when the current transaction is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q <= bl_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || m_axis_tready) begin
      out_q <= bl_res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q.q;
  assign m_axis_tuser  = out_q.path;

  // A result leaving the pipeline into a free output slot shows up next cycle
  a_result_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bl_v && (!out_v_q || m_axis_tready) |=> m_axis_tvalid)
    else $error("pipeline result did not reach the output register");

  // Backpressure at the input only comes from a stalled, full output
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && bl_v))
    else $error("input stalled without a blocked output");

  // A held pipeline keeps its last result
  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> bl_v && $stable(bl_res))
    else $error("stalled pipeline lost its last result");

endmodule

// ----- sim/tb_top.sv -----
// Testbench for quaternion_slerp_core: random and directed stream traffic, scoreboard check.
// Depends on qslerp_pkg and the quaternion_slerp_core RTL.
`timescale 1ns / 1ps

// Expected-result store plus the fixed-point slerp predictor
class slerp_scoreboard;
  typedef struct {
    logic [3:0][15:0] q;
    qslerp_pkg::path_e path;
  } slerp_res_t;

  slerp_res_t pending_q[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  static function longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  static function longint isqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  static function longint angle_of(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < qslerp_pkg::CORDIC_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(qslerp_pkg::atan_q16(i));
      end else begin
        x -= dx; y += dy; z -= longint'(qslerp_pkg::atan_q16(i));
      end
    end
    return z;
  endfunction

  static function longint sine_of(longint a);
    longint x, y, dx, dy;
    x = 39797;
    y = 0;
    for (int i = 0; i < qslerp_pkg::CORDIC_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= longint'(qslerp_pkg::atan_q16(i));
      end else begin
        x += dx; y -= dy; a += longint'(qslerp_pkg::atan_q16(i));
      end
    end
    return y;
  endfunction

  // Compute the interpolated quaternion for one transaction and queue it
  function void note_input(logic [151:0] data);
    longint f[4], g[4], t, c, w0, w1, s2, r, inv, om, v;
    bit same;
    slerp_res_t e;
    same = 1;
    for (int k = 0; k < 4; k++) begin
      f[k] = longint'($signed(data[16*k +: 16]));
      g[k] = longint'($signed(data[64 + 16*k +: 16]));
      if (f[k] != g[k]) same = 0;
    end
    t = longint'($signed(data[128 +: 18]));
    if (t <= 0 || t >= 65536 || same) begin
      e.path = (t <= 0) ? qslerp_pkg::PATH_FROM : qslerp_pkg::PATH_TO;
      for (int k = 0; k < 4; k++) e.q[k] = (t <= 0) ? f[k][15:0] : g[k][15:0];
    end else begin
      c = 0;
      for (int k = 0; k < 4; k++) c += f[k] * g[k];
      if (c < 0) begin
        c = -c;
        for (int k = 0; k < 4; k++) g[k] = -g[k];
      end
      if ((64'sd1 << 30) - c > 1024) begin
        s2 = (64'sd1 << 30) - ((c * c) >>> 30);
        r = isqrt(longint'(s2) << 30);
        inv = (r != 0) ? (64'sd1 << 46) / r : (64'sd1 << 46);
        om = angle_of(c >>> 14, r >>> 14);
        w0 = (sine_of(((65536 - t) * om) >>> 16) * inv) >>> 16;
        w1 = (sine_of((t * om) >>> 16) * inv) >>> 16;
        e.path = qslerp_pkg::PATH_SPHERE;
      end else begin
        w0 = 65536 - t;
        w1 = t;
        e.path = qslerp_pkg::PATH_LINEAR;
      end
      for (int k = 0; k < 4; k++) begin
        v = (w0 * f[k] + w1 * g[k] + 32768) >>> 16;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        e.q[k] = v[15:0];
      end
    end
    pending_q.push_back(e);
  endfunction

  // Compare one output transaction with the oldest expectation
  function void check_result(logic [63:0] data, logic [1:0] user);
    slerp_res_t e;
    if (pending_q.size() == 0) begin
      $error("unexpected result tdata=%h tuser=%0d", data, user);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    for (int k = 0; k < 4; k++)
      if (data[16*k +: 16] !== e.q[k]) begin
        $error("out_%s expected %0d actual %0d", k == 0 ? "w" : k == 1 ? "x" : k == 2 ? "y" : "z",
               $signed(e.q[k]), $signed(data[16*k +: 16]));
        errors++;
      end
    if (user !== e.path) begin
      $error("path_taken expected %0d actual %0d", e.path, user);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import qslerp_pkg::*;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [USER_W-1:0] m_axis_tuser;
  int send_idle_pct, recv_idle_pct;

  slerp_scoreboard sb;

  quaternion_slerp_core dut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Sample output transactions at the rising edge
  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);

  // Randomize receiver readiness at the falling edge
  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(600)) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [17:0] rand_blend();
    case ($urandom_range(9))
      0: return 18'($urandom);
      1: return 18'd0;
      2: return 18'd65536;
      3: return 18'd1;
      4: return 18'd65535;
      default: return 18'($urandom_range(65535, 1));
    endcase
  endfunction

  // Send one transaction, with random idle gaps before it
  task automatic send_item(logic [15:0] fq[4], logic [15:0] gq[4], logic [17:0] tb);
    logic [IN_W-1:0] d;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    d = '0;
    for (int k = 0; k < 4; k++) begin
      d[16*k +: 16] = fq[k];
      d[64 + 16*k +: 16] = gq[k];
    end
    d[128 +: 18] = tb;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(d);
    @(negedge clk_i);
  endtask

  task automatic random_item();
    logic [15:0] fq[4], gq[4];
    int mode;
    mode = $urandom_range(9);
    for (int k = 0; k < 4; k++) begin
      fq[k] = rand_comp();
      case (mode)
        0: gq[k] = fq[k];
        1: gq[k] = fq[k] + 16'(int'($urandom_range(8)) - 4);
        2: gq[k] = -fq[k] + 16'(int'($urandom_range(8)) - 4);
        default: gq[k] = rand_comp();
      endcase
    end
    if ($urandom_range(3) == 0) begin
      // unit quaternions along axes give clean spherical cases
      fq = '{16'd23170, 16'd23170, 16'd0, 16'd0};
      gq = '{16'd23170, 16'd0, 16'd23170, 16'd0};
      if ($urandom_range(1)) gq[1] = 16'(-23170);
    end
    send_item(fq, gq, rand_blend());
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [15:0] a[4], b[4];
    sb = new();
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    m_axis_tready = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed: copies, identical inputs, extremes, saturation, near and far pairs
    a = '{16'h7fff, 16'h8000, 16'h0001, 16'hffff};
    b = '{16'h8000, 16'h7fff, 16'hfffe, 16'h0002};
    send_item(a, b, 18'd0);
    send_item(a, b, 18'h20000);
    send_item(a, b, 18'd65536);
    send_item(a, b, 18'h1ffff);
    send_item(a, a, 18'd30000);
    send_item(a, b, 18'd1);
    send_item(a, b, 18'd65535);
    send_item(a, b, 18'd32768);
    a = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
    b = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7ffe};
    send_item(a, b, 18'd32768);
    b = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};
    send_item(a, b, 18'd20000);
    a = '{16'd32767, 16'd0, 16'd0, 16'd0};
    b = '{16'd0, 16'd32767, 16'd0, 16'd0};
    send_item(a, b, 18'd32768);
    send_item(a, b, 18'd100);
    b = '{16'd23170, 16'd23170, 16'd0, 16'd0};
    send_item(a, b, 18'd50000);
    b = '{16'(-23170), 16'd23170, 16'd0, 16'd0};
    send_item(a, b, 18'd16384);
    b = '{16'd32767, 16'd1, 16'd0, 16'd0};
    send_item(a, b, 18'd40000);
    a = '{16'd0, 16'd0, 16'd0, 16'd0};
    b = '{16'd0, 16'd0, 16'd5, 16'd0};
    send_item(a, b, 18'd40000);
    wait_drain();

    // Random traffic in three idling phases
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 25 : (p == 1) ? 75 : 0;
      recv_idle_pct = (p == 0) ? 75 : (p == 1) ? 25 : 0;
      for (int i = 0; i < 480; i++) random_item();
      wait_drain();
    end
    repeat (200) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end
endmodule
